>>> sv/dtf_pkg.sv
`timescale 1ns / 1ps
// Shared constants, codes and types for the detection filter with top-k selection.
// No dependencies.
package dtf_pkg;

   localparam int DEF_MAX_CANDIDATES = 1024;
   localparam int DEF_MAX_ATTRIBUTES = 128;
   localparam int DEF_VALUE_BITS     = 24;

   localparam int BOX_FIELDS = 5;
   localparam int OBJ_POS    = 4;
   localparam int FRAC_BITS  = 12;

   localparam int CLASS_BITS     = 7;
   localparam int TOTAL_BITS     = 11;
   localparam int THR_BITS       = 23;
   localparam int LIMIT_BITS     = 11;
   localparam int APR_BITS       = 8;
   localparam int CSR_DATA_BITS  = 23;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [THR_BITS-1:0]   THR_RESET   = THR_BITS'(1024);
   localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = '0;
   localparam logic [APR_BITS-1:0]   APR_RESET   = APR_BITS'(85);

   typedef enum logic [0:0] {
      OP_PUSH = 1'b0,
      OP_READ = 1'b1
   } opcode_type;

   typedef enum logic [1:0] {
      KIND_SUMMARY = 2'd0,
      KIND_BOX     = 2'd1,
      KIND_EMPTY   = 2'd2
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_THRESHOLD = 2'd0,
      REG_LIMIT     = 2'd1,
      REG_ATTRS     = 2'd2
   } csr_reg_type;

   // chain command: clear all, insert one candidate, pop the head
   typedef struct packed {
      logic clr;
      logic ins;
      logic pop;
   } ctl_type;

endpackage

>>> sv/dtf_if.sv
`timescale 1ns / 1ps
// Request and response channel interfaces (valid/ready, one beat per item).
// Depends on dtf_pkg.
interface dtf_req_if #(
   parameter int VALUE_BITS = dtf_pkg::DEF_VALUE_BITS
);
   import dtf_pkg::*;
   logic                         valid;
   logic                         ready;
   opcode_type                   opcode;
   logic signed [VALUE_BITS-1:0] element_value;
   logic                         frame_end;

   modport source (output valid, opcode, element_value, frame_end, input ready);
   modport sink   (input valid, opcode, element_value, frame_end, output ready);
endinterface

interface dtf_rsp_if #(
   parameter int VALUE_BITS = dtf_pkg::DEF_VALUE_BITS
);
   import dtf_pkg::*;
   logic                         valid;
   logic                         ready;
   kind_type                     result_kind;
   logic signed [VALUE_BITS-1:0] center_x;
   logic signed [VALUE_BITS-1:0] center_y;
   logic signed [VALUE_BITS-1:0] box_width;
   logic signed [VALUE_BITS-1:0] box_height;
   logic signed [VALUE_BITS-1:0] best_score;
   logic [CLASS_BITS-1:0]        class_index;
   logic [TOTAL_BITS-1:0]        box_total;
   logic                         store_overflow;

   modport source (output valid, result_kind, center_x, center_y, box_width, box_height,
                   best_score, class_index, box_total, store_overflow, input ready);
   modport sink   (input valid, result_kind, center_x, center_y, box_width, box_height,
                   best_score, class_index, box_total, store_overflow, output ready);
endinterface

>>> sv/dtf_cell.sv
`timescale 1ns / 1ps
// One slot of the sorted candidate chain: holds a score and a candidate index.
// Depends on dtf_pkg.
module dtf_cell #(
   parameter int  SCORE_BITS = dtf_pkg::DEF_VALUE_BITS,
   parameter int  INDEX_BITS = 10,
   parameter bit  IS_HEAD    = 1'b0
)(
   input  logic                         clock,
   input  logic                         reset,
   input  dtf_pkg::ctl_type             ctl,
   input  logic signed [SCORE_BITS-1:0] new_score,
   input  logic [INDEX_BITS-1:0]        new_index,
   input  logic                         left_valid,
   input  logic signed [SCORE_BITS-1:0] left_score,
   input  logic [INDEX_BITS-1:0]        left_index,
   input  logic                         right_valid,
   input  logic signed [SCORE_BITS-1:0] right_score,
   input  logic [INDEX_BITS-1:0]        right_index,
   output logic                         valid,
   output logic signed [SCORE_BITS-1:0] score,
   output logic [INDEX_BITS-1:0]        index
);
   import dtf_pkg::*;

   logic                         valid_ff;
   logic signed [SCORE_BITS-1:0] score_ff;
   logic [INDEX_BITS-1:0]        index_ff;
   logic                         self_ge;
   logic                         left_ge;

   // equal scores stay ahead: the earlier box wins a tie
   assign self_ge = valid_ff && (score_ff >= new_score);
   assign left_ge = IS_HEAD ? 1'b1 : (left_valid && (left_score >= new_score));

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.clr) begin
         valid_ff <= 1'b0;
      end else if (ctl.ins) begin
         if (!self_ge) begin
            if (left_ge) begin
               valid_ff <= 1'b1;
               score_ff <= new_score;
               index_ff <= new_index;
            end else begin
               valid_ff <= left_valid;
               score_ff <= left_score;
               index_ff <= left_index;
            end
         end
      end else if (ctl.pop) begin
         valid_ff <= right_valid;
         score_ff <= right_score;
         index_ff <= right_index;
      end
   end

   assign valid = valid_ff;
   assign score = score_ff;
   assign index = index_ff;
endmodule

>>> sv/dtf_chain.sv
`timescale 1ns / 1ps
// Row of dtf_cell slots kept in descending score order; head is the best candidate.
// Depends on dtf_pkg and dtf_cell.
module dtf_chain #(
   parameter int DEPTH      = dtf_pkg::DEF_MAX_CANDIDATES,
   parameter int SCORE_BITS = dtf_pkg::DEF_VALUE_BITS,
   parameter int INDEX_BITS = 10
)(
   input  logic                         clock,
   input  logic                         reset,
   input  dtf_pkg::ctl_type             ctl,
   input  logic signed [SCORE_BITS-1:0] new_score,
   input  logic [INDEX_BITS-1:0]        new_index,
   output logic                         head_valid,
   output logic [INDEX_BITS-1:0]        head_index
);
   import dtf_pkg::*;

   logic                         v_w [0:DEPTH];
   logic signed [SCORE_BITS-1:0] s_w [0:DEPTH];
   logic [INDEX_BITS-1:0]        i_w [0:DEPTH];

   assign v_w[DEPTH] = 1'b0;
   assign s_w[DEPTH] = '0;
   assign i_w[DEPTH] = '0;

   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      if (g == 0) begin : g_head
         dtf_cell #(.SCORE_BITS(SCORE_BITS), .INDEX_BITS(INDEX_BITS), .IS_HEAD(1'b1)) u_cell (
            .clock(clock), .reset(reset), .ctl(ctl),
            .new_score(new_score), .new_index(new_index),
            .left_valid(1'b0), .left_score('0), .left_index('0),
            .right_valid(v_w[g+1]), .right_score(s_w[g+1]), .right_index(i_w[g+1]),
            .valid(v_w[g]), .score(s_w[g]), .index(i_w[g])
         );
      end else begin : g_body
         dtf_cell #(.SCORE_BITS(SCORE_BITS), .INDEX_BITS(INDEX_BITS), .IS_HEAD(1'b0)) u_cell (
            .clock(clock), .reset(reset), .ctl(ctl),
            .new_score(new_score), .new_index(new_index),
            .left_valid(v_w[g-1]), .left_score(s_w[g-1]), .left_index(i_w[g-1]),
            .right_valid(v_w[g+1]), .right_score(s_w[g+1]), .right_index(i_w[g+1]),
            .valid(v_w[g]), .score(s_w[g]), .index(i_w[g])
         );
      end
   end

   assign head_valid = v_w[0];
   assign head_index = i_w[0];
endmodule

>>> sv/detection_filter_topk.sv
`timescale 1ns / 1ps
// Detection row filter with top-k selection; top level.
// Depends on dtf_pkg, dtf_if (dtf_req_if, dtf_rsp_if) and dtf_chain.
// Push beats: one per cycle; a kept row enters the sorted chain from the registered score stage.
// Frame-end push or read: accept sets b_fe_ff or rd1_ff, then the response is registered (read:
// store read at accept, then output stage); beats wait on either flag and on a waiting response.
// Synchronous active-high reset clears control state and chain valid bits; stores are not swept.
module detection_filter_topk #(
   parameter int MAX_CANDIDATES = dtf_pkg::DEF_MAX_CANDIDATES,
   parameter int MAX_ATTRIBUTES = dtf_pkg::DEF_MAX_ATTRIBUTES,
   parameter int VALUE_BITS     = dtf_pkg::DEF_VALUE_BITS
)(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_we,
   input  logic [dtf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [dtf_pkg::CSR_DATA_BITS-1:0]   csr_wdata,
   dtf_req_if.sink                             req_bus,
   dtf_rsp_if.source                           rsp_bus
);
   import dtf_pkg::*;

   localparam int AW = (MAX_CANDIDATES > 1) ? $clog2(MAX_CANDIDATES) : 1;
   localparam int CW = $clog2(MAX_CANDIDATES + 1);
   localparam int TW = ((CW > LIMIT_BITS) ? CW : LIMIT_BITS) + 1;
   localparam int PW = $clog2(MAX_ATTRIBUTES);
   localparam int EW = ((PW > APR_BITS) ? PW : APR_BITS) + 1;
   localparam int HW = ((VALUE_BITS > THR_BITS) ? VALUE_BITS : THR_BITS) + 1;
   localparam int DW = 2 * VALUE_BITS;
   localparam logic signed [DW-1:0] SAT_HI = {{(VALUE_BITS+1){1'b0}}, {(VALUE_BITS-1){1'b1}}};
   localparam logic signed [DW-1:0] SAT_LO = ~SAT_HI;

   // configuration
   logic [THR_BITS-1:0]   thr_ff;
   logic [LIMIT_BITS-1:0] lim_ff;
   logic [APR_BITS-1:0]   apr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= THR_RESET;
         lim_ff <= LIMIT_RESET;
         apr_ff <= APR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            REG_THRESHOLD: thr_ff <= csr_wdata[THR_BITS-1:0];
            REG_LIMIT:     lim_ff <= csr_wdata[LIMIT_BITS-1:0];
            REG_ATTRS:     apr_ff <= csr_wdata[APR_BITS-1:0];
            default:       ;
         endcase
      end
   end

   // frame and row state
   logic [PW-1:0]                pos_ff;
   logic signed [VALUE_BITS-1:0] box_ff [0:BOX_FIELDS-1];
   logic signed [VALUE_BITS-1:0] best_s_ff;
   logic [CLASS_BITS-1:0]        best_c_ff;
   logic [CW-1:0]                cnt_ff;
   logic [CW-1:0]                rp_ff;
   logic [CW-1:0]                total_ff;
   logic                         ovf_ff;
   logic                         closed_ff;
   logic                         sorted_ff;

   // score stage
   logic signed [DW-1:0]         prod_ff;
   logic                         b_cls_ff;
   logic                         b_first_ff;
   logic [CLASS_BITS-1:0]        b_c_ff;
   logic                         b_store_ff;
   logic                         b_fe_ff;
   logic signed [VALUE_BITS-1:0] snap_ff [0:3];

   // read stage
   logic                         rd1_ff;
   logic                         rd_box_ff;
   logic [DW-1:0]                pos_q_ff;
   logic [DW-1:0]                ext_q_ff;
   logic [VALUE_BITS+CLASS_BITS-1:0] sc_q_ff;

   // stores
   logic [DW-1:0]                     pos_mem [0:MAX_CANDIDATES-1];
   logic [DW-1:0]                     ext_mem [0:MAX_CANDIDATES-1];
   logic [VALUE_BITS+CLASS_BITS-1:0]  sc_mem  [0:MAX_CANDIDATES-1];

   // response register
   logic                         rsp_valid_ff;
   kind_type                     kind_ff;
   logic signed [VALUE_BITS-1:0] cx_ff, cy_ff, bw_ff, bh_ff, bs_ff;
   logic [CLASS_BITS-1:0]        ci_ff;
   logic [TOTAL_BITS-1:0]        bt_ff;
   logic                         so_ff;

   // handshake
   logic pend;
   logic req_fire;
   logic push_go;
   logic read_go;
   logic rsp_take;

   assign pend     = b_fe_ff || rd1_ff;
   assign req_bus.ready = !pend && (!rsp_valid_ff || rsp_bus.ready);
   assign req_fire = req_bus.valid && req_bus.ready;
   assign push_go  = req_fire && (req_bus.opcode == OP_PUSH);
   assign read_go  = req_fire && (req_bus.opcode == OP_READ);
   assign rsp_take = rsp_valid_ff && rsp_bus.ready;

   // row position and close
   logic [EW-1:0] len_e;
   logic [EW-1:0] p_e;
   logic          row_close;
   logic          is_cls;
   logic          kept;

   always_comb begin
      len_e = EW'(apr_ff);
      if (len_e < EW'(BOX_FIELDS + 1)) len_e = EW'(BOX_FIELDS + 1);
      if (len_e > EW'(MAX_ATTRIBUTES)) len_e = EW'(MAX_ATTRIBUTES);
   end

   assign p_e       = EW'(pos_ff);
   assign row_close = (p_e + EW'(1)) >= len_e;
   assign is_cls    = p_e >= EW'(BOX_FIELDS);
   assign kept      = $signed(HW'(box_ff[OBJ_POS])) > $signed(HW'(thr_ff));

   // score: floor shift and saturate
   logic signed [DW-1:0]         prod_sh;
   logic signed [VALUE_BITS-1:0] score_sat;
   logic                         better;
   logic signed [VALUE_BITS-1:0] nb_s;
   logic [CLASS_BITS-1:0]        nb_c;
   logic                         full;
   logic                         wr_go;
   logic [CW-1:0]                n_new;
   logic                         sort_new;

   assign prod_sh   = prod_ff >>> FRAC_BITS;
   assign score_sat = (prod_sh > SAT_HI) ? VALUE_BITS'(SAT_HI) :
                      (prod_sh < SAT_LO) ? VALUE_BITS'(SAT_LO) : VALUE_BITS'(prod_sh);
   assign better    = b_first_ff || (score_sat > best_s_ff);
   assign nb_s      = better ? score_sat : best_s_ff;
   assign nb_c      = better ? b_c_ff : best_c_ff;
   assign full      = cnt_ff >= CW'(MAX_CANDIDATES);
   assign wr_go     = b_store_ff && !full;
   assign n_new     = cnt_ff + CW'(wr_go);
   assign sort_new  = (lim_ff != '0) && (TW'(n_new) > TW'(lim_ff));

   // read address
   logic          avail;
   logic          rd_go;
   logic          head_valid;
   logic [AW-1:0] head_index;
   logic [AW-1:0] rd_addr;

   assign avail   = closed_ff && (rp_ff < total_ff);
   assign rd_go   = read_go && avail;
   assign rd_addr = sorted_ff ? head_index : rp_ff[AW-1:0];

   ctl_type chain_ctl;
   assign chain_ctl.clr = push_go && closed_ff;
   assign chain_ctl.ins = wr_go;
   assign chain_ctl.pop = rd_go && sorted_ff;

   dtf_chain #(.DEPTH(MAX_CANDIDATES), .SCORE_BITS(VALUE_BITS), .INDEX_BITS(AW)) u_chain (
      .clock(clock), .reset(reset), .ctl(chain_ctl),
      .new_score(nb_s), .new_index(cnt_ff[AW-1:0]),
      .head_valid(head_valid), .head_index(head_index)
   );

   always_ff @(posedge clock) begin
      if (wr_go) begin
         pos_mem[cnt_ff[AW-1:0]] <= {snap_ff[1], snap_ff[0]};
         ext_mem[cnt_ff[AW-1:0]] <= {snap_ff[3], snap_ff[2]};
         sc_mem[cnt_ff[AW-1:0]]  <= {nb_s, nb_c};
      end
      if (rd_go) begin
         pos_q_ff <= pos_mem[rd_addr];
         ext_q_ff <= ext_mem[rd_addr];
         sc_q_ff  <= sc_mem[rd_addr];
      end
   end

   // push path, frame control and read bookkeeping
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         cnt_ff     <= '0;
         rp_ff      <= '0;
         total_ff   <= '0;
         ovf_ff     <= 1'b0;
         closed_ff  <= 1'b0;
         sorted_ff  <= 1'b0;
         b_cls_ff   <= 1'b0;
         b_store_ff <= 1'b0;
         b_fe_ff    <= 1'b0;
         rd1_ff     <= 1'b0;
         rd_box_ff  <= 1'b0;
         best_s_ff  <= '0;
         best_c_ff  <= '0;
         for (int i = 0; i < BOX_FIELDS; i++) box_ff[i] <= '0;
      end else begin
         b_cls_ff   <= push_go && is_cls;
         b_store_ff <= push_go && is_cls && row_close && kept;
         b_fe_ff    <= push_go && req_bus.frame_end;
         rd1_ff     <= read_go;
         rd_box_ff  <= rd_go;

         if (push_go) begin
            prod_ff    <= box_ff[OBJ_POS] * req_bus.element_value;
            b_first_ff <= p_e == EW'(BOX_FIELDS);
            b_c_ff     <= CLASS_BITS'(p_e - EW'(BOX_FIELDS));
            for (int i = 0; i < 4; i++) snap_ff[i] <= box_ff[i];
            for (int i = 0; i < BOX_FIELDS; i++) begin
               if (p_e == EW'(i)) box_ff[i] <= req_bus.element_value;
            end
            pos_ff <= (row_close || req_bus.frame_end) ? '0 : pos_ff + PW'(1);
            if (closed_ff) begin
               closed_ff <= 1'b0;
               cnt_ff    <= '0;
               ovf_ff    <= 1'b0;
               total_ff  <= '0;
               rp_ff     <= '0;
            end
         end

         if (b_cls_ff) begin
            best_s_ff <= nb_s;
            best_c_ff <= nb_c;
         end
         if (wr_go) cnt_ff <= n_new;
         if (b_store_ff && full) ovf_ff <= 1'b1;
         if (b_fe_ff) begin
            closed_ff <= 1'b1;
            sorted_ff <= sort_new;
            total_ff  <= sort_new ? CW'(lim_ff) : n_new;
            rp_ff     <= '0;
         end

         if (rd_go) rp_ff <= rp_ff + CW'(1);
      end
   end

   // response register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_take) rsp_valid_ff <= 1'b0;
         if (b_fe_ff) begin
            rsp_valid_ff <= 1'b1;
            kind_ff <= KIND_SUMMARY;
            cx_ff   <= '0;
            cy_ff   <= '0;
            bw_ff   <= '0;
            bh_ff   <= '0;
            bs_ff   <= '0;
            ci_ff   <= '0;
            bt_ff   <= TOTAL_BITS'(sort_new ? CW'(lim_ff) : n_new);
            so_ff   <= ovf_ff || (b_store_ff && full);
         end else if (rd1_ff) begin
            rsp_valid_ff <= 1'b1;
            if (rd_box_ff) begin
               kind_ff <= KIND_BOX;
               cx_ff   <= pos_q_ff[VALUE_BITS-1:0];
               cy_ff   <= pos_q_ff[DW-1:VALUE_BITS];
               bw_ff   <= ext_q_ff[VALUE_BITS-1:0];
               bh_ff   <= ext_q_ff[DW-1:VALUE_BITS];
               bs_ff   <= sc_q_ff[VALUE_BITS+CLASS_BITS-1:CLASS_BITS];
               ci_ff   <= sc_q_ff[CLASS_BITS-1:0];
               bt_ff   <= TOTAL_BITS'(total_ff);
               so_ff   <= ovf_ff;
            end else begin
               kind_ff <= KIND_EMPTY;
               cx_ff   <= '0;
               cy_ff   <= '0;
               bw_ff   <= '0;
               bh_ff   <= '0;
               bs_ff   <= '0;
               ci_ff   <= '0;
               bt_ff   <= '0;
               so_ff   <= 1'b0;
            end
         end
      end
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.result_kind    = kind_ff;
   assign rsp_bus.center_x       = cx_ff;
   assign rsp_bus.center_y       = cy_ff;
   assign rsp_bus.box_width      = bw_ff;
   assign rsp_bus.box_height     = bh_ff;
   assign rsp_bus.best_score     = bs_ff;
   assign rsp_bus.class_index    = ci_ff;
   assign rsp_bus.box_total      = bt_ff;
   assign rsp_bus.store_overflow = so_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CW'(MAX_CANDIDATES))
      else $error("candidate count beyond store depth");

   a_read_answers: assert property (@(posedge clock) disable iff (reset)
      rd1_ff |=> rsp_valid_ff)
      else $error("read beat produced no response");

   a_no_insert_closed: assert property (@(posedge clock) disable iff (reset)
      closed_ff |-> !b_store_ff)
      else $error("candidate stored into a closed frame");

   a_sorted_head: assert property (@(posedge clock) disable iff (reset)
      (rd_go && sorted_ff) |-> head_valid)
      else $error("sorted read with empty chain head");
endmodule

>>> bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for detection_filter_topk: random frames of detection rows and
// reads, checked beat by beat against a scoreboard that predicts filtering and top-k.
// Depends on dtf_pkg, dtf_if and the detection_filter_topk RTL.
module testbench;
   import dtf_pkg::*;

   localparam int VB        = DEF_VALUE_BITS;
   localparam int STORE_MAX = DEF_MAX_CANDIDATES;
   localparam int ROW_MAX   = DEF_MAX_ATTRIBUTES;
   localparam int CYCLE_CAP = 3000000;
   localparam int SETTLE    = 12;

   typedef struct {
      kind_type              kind;
      logic signed [VB-1:0]  cx, cy, w, h, score;
      logic [CLASS_BITS-1:0] cls;
      logic [TOTAL_BITS-1:0] total;
      logic                  ovf;
   } box_beat_t;

   class detection_scoreboard;
      int unsigned threshold = 1024, limit = 0, row_len = 85;
      int unsigned position, kept, rd_ptr, readable;
      bit          overflow, closed;
      longint      row_fields[BOX_FIELDS];
      longint      row_score;
      int unsigned row_class;
      box_beat_t   kept_boxes[STORE_MAX];
      int unsigned read_order[STORE_MAX];
      box_beat_t   pending[$];
      int          errors;

      function longint scaled_score(longint a, longint b);
         longint q;
         q = (a * b) >>> FRAC_BITS;
         if (q > 8388607) q = 8388607;
         if (q < -8388608) q = -8388608;
         return q;
      endfunction

      function void close_frame();
         int unsigned pick;
         int j;
         for (int i = 0; i < kept; i++) read_order[i] = i;
         readable = kept;
         if (limit > 0 && kept > limit) begin
            for (int i = 1; i < kept; i++) begin
               pick = read_order[i];
               j = i;
               while (j > 0 && kept_boxes[read_order[j-1]].score < kept_boxes[pick].score) begin
                  read_order[j] = read_order[j-1];
                  j--;
               end
               read_order[j] = pick;
            end
            readable = limit;
         end
         rd_ptr = 0;
         position = 0;
         closed = 1;
      endfunction

      function void note_input(opcode_type op, logic [VB-1:0] raw, logic last);
         box_beat_t   r;
         longint      v, s;
         int unsigned len;
         r = '{kind: KIND_EMPTY, cx: 0, cy: 0, w: 0, h: 0, score: 0, cls: 0, total: 0, ovf: 0};
         if (op == OP_READ) begin
            if (closed && rd_ptr < readable) begin
               r = kept_boxes[read_order[rd_ptr]];
               r.kind  = KIND_BOX;
               r.total = TOTAL_BITS'(readable);
               r.ovf   = overflow;
               rd_ptr++;
            end
            pending.push_back(r);
            return;
         end
         if (closed) begin
            closed = 0; kept = 0; overflow = 0; readable = 0; rd_ptr = 0; position = 0;
         end
         v = longint'($signed(raw));
         len = row_len < 6 ? 6 : (row_len > ROW_MAX ? ROW_MAX : row_len);
         if (position < BOX_FIELDS) row_fields[position] = v;
         else begin
            s = scaled_score(row_fields[OBJ_POS], v);
            if (position == BOX_FIELDS || s > row_score) begin
               row_score = s;
               row_class = position - BOX_FIELDS;
            end
         end
         if (position >= len - 1) begin
            if (position >= BOX_FIELDS && row_fields[OBJ_POS] > longint'(threshold)) begin
               if (kept < STORE_MAX) begin
                  kept_boxes[kept].cx    = VB'(row_fields[0]);
                  kept_boxes[kept].cy    = VB'(row_fields[1]);
                  kept_boxes[kept].w     = VB'(row_fields[2]);
                  kept_boxes[kept].h     = VB'(row_fields[3]);
                  kept_boxes[kept].score = VB'(row_score);
                  kept_boxes[kept].cls   = CLASS_BITS'(row_class);
                  kept++;
               end else overflow = 1;
            end
            position = 0;
         end else position++;
         if (last) begin
            close_frame();
            r.kind  = KIND_SUMMARY;
            r.total = TOTAL_BITS'(readable);
            r.ovf   = overflow;
            pending.push_back(r);
         end
      endfunction

      function void check_result(box_beat_t got);
         box_beat_t want;
         longint    e[9], a[9];
         string     names[9] = '{"result_kind", "center_x", "center_y", "box_width",
                                 "box_height", "best_score", "class_index", "box_total",
                                 "store_overflow"};
         if (pending.size() == 0) begin
            $display("%0t: unexpected result beat, kind %0d", $time, got.kind);
            errors++;
            return;
         end
         want = pending.pop_front();
         e = '{want.kind, want.cx, want.cy, want.w, want.h, want.score, want.cls,
               want.total, want.ovf};
         a = '{got.kind, got.cx, got.cy, got.w, got.h, got.score, got.cls,
               got.total, got.ovf};
         for (int i = 0; i < 9; i++)
            if (e[i] !== a[i]) begin
               $display("%0t: %s expected %0d got %0d", $time, names[i], e[i], a[i]);
               errors++;
            end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic csr_we = 0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   dtf_req_if req_bus ();
   dtf_rsp_if rsp_bus ();

   detection_filter_topk dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   detection_scoreboard board = new();
   int unsigned cycles, burst_left, stall_pct, items_sent;
   box_beat_t   seen;

   always #5 clock = ~clock;

   initial begin
      req_bus.valid = 0;
      req_bus.opcode = OP_PUSH;
      req_bus.element_value = '0;
      req_bus.frame_end = 0;
      rsp_bus.ready = 0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_CAP) begin
         $display("detection_filter_topk regression: fail");
         $finish;
      end
   end

   // receiver: stall density is redrawn at random periodically
   always @(posedge clock) begin
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         seen.kind  = rsp_bus.result_kind;
         seen.cx    = rsp_bus.center_x;
         seen.cy    = rsp_bus.center_y;
         seen.w     = rsp_bus.box_width;
         seen.h     = rsp_bus.box_height;
         seen.score = rsp_bus.best_score;
         seen.cls   = rsp_bus.class_index;
         seen.total = rsp_bus.box_total;
         seen.ovf   = rsp_bus.store_overflow;
         board.check_result(seen);
      end
      if (cycles % 400 == 0) begin
         case ($urandom_range(0, 3))
            0: stall_pct = 0;
            1: stall_pct = 25;
            2: stall_pct = 60;
            default: stall_pct = 90;
         endcase
      end
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   task automatic send_beat(opcode_type op, logic [VB-1:0] value, logic last);
      req_bus.valid         <= 1;
      req_bus.opcode        <= op;
      req_bus.element_value <= value;
      req_bus.frame_end     <= last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      board.note_input(op, value, last);
      items_sent++;
      if (burst_left > 0) burst_left--;
      if (burst_left == 0) begin
         req_bus.valid <= 0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? 300 : $urandom_range(1, 20);
      end
   endtask

   task automatic drain();
      req_bus.valid <= 0;
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_reg(csr_reg_type idx, int unsigned data);
      csr_we    <= 1;
      csr_index <= idx;
      csr_wdata <= CSR_DATA_BITS'(data);
      @(posedge clock);
      csr_we <= 0;
      case (idx)
         REG_THRESHOLD: board.threshold = data & 32'h7F_FFFF;
         REG_LIMIT:     board.limit     = data & 32'h7FF;
         default:       board.row_len   = data & 32'hFF;
      endcase
      @(posedge clock);
   endtask

   task automatic set_filter(int unsigned thr, int unsigned lim, int unsigned len);
      drain();
      write_reg(REG_THRESHOLD, thr);
      write_reg(REG_LIMIT, lim);
      write_reg(REG_ATTRS, len);
   endtask

   task automatic push_row(logic [VB-1:0] f[$], logic last);
      foreach (f[i]) send_beat(OP_PUSH, f[i], last && i == f.size() - 1);
   endtask

   task automatic read_boxes(int n);
      repeat (n) send_beat(OP_READ, VB'($urandom()), 1'($urandom_range(0, 1)));
   endtask

   function automatic logic [VB-1:0] pick_objectness();
      case ($urandom_range(0, 6))
         0: return VB'(board.threshold);
         1: return VB'(board.threshold + 1);
         2: return VB'($urandom());
         3: return VB'(-$urandom_range(0, 5000));
         4: return 24'h7F_FFFF;
         default: return VB'(board.threshold + $urandom_range(1, 20000));
      endcase
   endfunction

   function automatic logic [VB-1:0] pick_confidence();
      case ($urandom_range(0, 3))
         0: return VB'($urandom());
         1: return VB'($urandom_range(0, 3) * 4096);
         2: return VB'(-$urandom_range(0, 8192));
         default: return VB'($urandom_range(0, 4096));
      endcase
   endfunction

   task automatic random_row(int len, logic last);
      logic [VB-1:0] f[$];
      for (int i = 0; i < len; i++)
         f.push_back(i == OBJ_POS ? pick_objectness() :
                     (i < BOX_FIELDS ? VB'($urandom()) : pick_confidence()));
      push_row(f, last);
   endtask

   task automatic random_frame();
      int rows, len, partial;
      case ($urandom_range(0, 9))
         0: set_filter($urandom_range(0, 3) == 0 ? 23'h7F_FFFF : 0, $urandom_range(0, 1024),
                       $urandom_range(0, 1) ? 0 : 255);
         1, 2: set_filter($urandom_range(0, 8192), $urandom_range(0, 5),
                          $urandom_range(6, 12));
         3: set_filter($urandom(), $urandom_range(0, 2047), $urandom_range(0, 255));
         default: ;
      endcase
      len = board.row_len < 6 ? 6 : (board.row_len > ROW_MAX ? ROW_MAX : board.row_len);
      rows = len > 40 ? $urandom_range(0, 3) : $urandom_range(0, 14);
      partial = ($urandom_range(0, 4) == 0) ? $urandom_range(1, len - 1) : 0;
      if (rows == 0 && partial == 0) partial = 1;
      if ($urandom_range(0, 5) == 0) read_boxes(1);
      for (int r = 0; r < rows; r++) random_row(len, r == rows - 1 && partial == 0);
      for (int i = 0; i < partial; i++) send_beat(OP_PUSH, VB'($urandom()), i == partial - 1);
      read_boxes(rows + int'($urandom_range(0, 2)) - int'($urandom_range(0, 2)));
   endtask

   initial begin
      logic [VB-1:0] row[$];
      burst_left = 1;
      stall_pct  = 0;
      repeat (7) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      read_boxes(1);
      set_filter(1024, 0, 6);
      row = '{24'h7F_FFFF, 24'h80_0000, 0, 24'hFF_FFFF, 24'h7F_FFFF, 24'h7F_FFFF};
      push_row(row, 0);
      row = '{1, 2, 3, 4, 24'h80_0000, 24'h80_0000};
      push_row(row, 0);
      row = '{5, 6, 7, 8, 1025, 24'hFF_FFFF};
      push_row(row, 0);
      row = '{9, 9, 9, 9, 1024, 4096};
      push_row(row, 0);
      row = '{1, 1, 1};
      push_row(row, 1);
      read_boxes(3);

      // row length shrinks while a row is half pushed
      set_filter(0, 1, 10);
      row = '{1, 2, 3, 4, 8192, 4096, 4096, 100};
      push_row(row, 0);
      drain();
      write_reg(REG_ATTRS, 7);
      row = '{4096, 10, 20, 30, 40, 8192, 4096, 8192, 4096};
      push_row(row, 1);
      read_boxes(2);

      while (items_sent < 850) random_frame();
      drain();   // sender pauses until every expected beat is back
      random_frame();

      req_bus.valid <= 0;
      while (board.pending.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
      if (board.errors == 0) begin
         $display("detection_filter_topk regression: pass");
      end else begin
         $display("detection_filter_topk regression: fail");
      end
      $finish;
   end

endmodule

>>> sim.f
sv/dtf_pkg.sv
sv/dtf_if.sv
sv/dtf_cell.sv
sv/dtf_chain.sv
sv/detection_filter_topk.sv
bench/testbench.sv
